// ===== rtl/ptpst_pkg.sv =====
// shared types and codes for the ptp sync timestamp table
// no dependencies
package ptpst_pkg;

   // default sizes
   localparam int TABLE_DEPTH_DEF = 32;
   localparam int PORT_BITS_DEF   = 6;

   // request modes
   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_FIND   = 2'd1;
   localparam logic [1:0] MODE_DELETE = 2'd2;

   // response status codes
   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_NO_MATCH = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   // per-cell control from the sequencer
   typedef struct packed {
      logic compare;   // capture match against the held request key
      logic load;      // write the request key and time into this cell
      logic shift;     // take the contents of the next younger cell
   } cell_ctrl_type;

endpackage

// ===== rtl/ptp_sync_timestamp_table.sv =====
// Table of PTP sync timestamps held as a row of cells in insertion order,
// oldest entry in cell 0. Add writes the cell at the fill count, find returns
// the time of the oldest entry whose five key fields all match, and delete
// removes that entry by moving every younger cell down one place, all in
// the same update. Each transaction runs through the idle, match and act
// states: the request is taken, every cell registers its key compare, and
// the table is updated and the response is loaded into the output register.
// A new request is taken only once the previous transaction is through; a
// stalled response holds the update step until the output register is free.
// The table is empty straight after reset, with no clearing pass.
module ptp_sync_timestamp_table
   import ptpst_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int PORT_BITS   = PORT_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_mode,
   input  logic [63:0]          req_clock_identity,
   input  logic [15:0]          req_port_number,
   input  logic [15:0]          req_sequence_id,
   input  logic [PORT_BITS-1:0] req_in_port,
   input  logic [PORT_BITS-1:0] req_out_port,
   input  logic signed [31:0]   req_nanoseconds,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic signed [31:0]   rsp_found_time
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MATCH = 2'd1;
   localparam logic [1:0] S_ACT   = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [1:0]           mode_ff;
   logic [63:0]          clock_id_ff;
   logic [15:0]          port_number_ff;
   logic [15:0]          sequence_id_ff;
   logic [PORT_BITS-1:0] in_port_ff;
   logic [PORT_BITS-1:0] out_port_ff;
   logic [31:0]          time_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           status_ff, status_in;
   logic [31:0]          found_ff, found_in;

   logic                 accept;
   logic                 go;
   logic                 full;
   logic                 hit;
   logic [31:0]          hit_time;
   logic [TABLE_DEPTH-1:0] shift_mask;

   // chain wiring, one slot beyond the last cell feeds an empty entry
   logic [TABLE_DEPTH:0]   ch_valid;
   logic [63:0]            ch_clock_id    [TABLE_DEPTH+1];
   logic [15:0]            ch_port_number [TABLE_DEPTH+1];
   logic [15:0]            ch_sequence_id [TABLE_DEPTH+1];
   logic [PORT_BITS-1:0]   ch_in_port     [TABLE_DEPTH+1];
   logic [PORT_BITS-1:0]   ch_out_port    [TABLE_DEPTH+1];
   logic [31:0]            ch_time        [TABLE_DEPTH+1];
   logic [31:0]            cell_time      [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] match;
   cell_ctrl_type          ctrl [TABLE_DEPTH];

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign go        = (state_ff == S_ACT) && (!rsp_valid_ff || !rsp_stall);
   assign full      = (count_ff == CW'(TABLE_DEPTH));

   // request hold register
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff        <= req_mode;
         clock_id_ff    <= req_clock_identity;
         port_number_ff <= req_port_number;
         sequence_id_ff <= req_sequence_id;
         in_port_ff     <= req_in_port;
         out_port_ff    <= req_out_port;
         time_ff        <= req_nanoseconds;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_MATCH;
         S_MATCH: state_in = S_ACT;
         S_ACT:   if (go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // end of the chain
   assign ch_valid[TABLE_DEPTH]       = 1'b0;
   assign ch_clock_id[TABLE_DEPTH]    = '0;
   assign ch_port_number[TABLE_DEPTH] = '0;
   assign ch_sequence_id[TABLE_DEPTH] = '0;
   assign ch_in_port[TABLE_DEPTH]     = '0;
   assign ch_out_port[TABLE_DEPTH]    = '0;
   assign ch_time[TABLE_DEPTH]        = '0;

   // row of cells
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      assign ctrl[i].compare = (state_ff == S_MATCH);
      assign ctrl[i].load    = go && (mode_ff == MODE_ADD) && (count_ff == CW'(i));
      assign ctrl[i].shift   = go && (mode_ff == MODE_DELETE) && shift_mask[i];
      assign cell_time[i]    = ch_time[i];

      ptpst_cell #(
         .PORT_BITS (PORT_BITS)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .ctrl            (ctrl[i]),
         .key_clock_id    (clock_id_ff),
         .key_port_number (port_number_ff),
         .key_sequence_id (sequence_id_ff),
         .key_in_port     (in_port_ff),
         .key_out_port    (out_port_ff),
         .key_time        (time_ff),
         .nbr_valid       (ch_valid[i+1]),
         .nbr_clock_id    (ch_clock_id[i+1]),
         .nbr_port_number (ch_port_number[i+1]),
         .nbr_sequence_id (ch_sequence_id[i+1]),
         .nbr_in_port     (ch_in_port[i+1]),
         .nbr_out_port    (ch_out_port[i+1]),
         .nbr_time        (ch_time[i+1]),
         .valid           (ch_valid[i]),
         .clock_id        (ch_clock_id[i]),
         .port_number     (ch_port_number[i]),
         .sequence_id     (ch_sequence_id[i]),
         .in_port         (ch_in_port[i]),
         .out_port        (ch_out_port[i]),
         .time_val        (ch_time[i]),
         .match           (match[i])
      );
   end

   ptpst_select #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_select (
      .match      (match),
      .cell_time  (cell_time),
      .hit        (hit),
      .shift_mask (shift_mask),
      .hit_time   (hit_time)
   );

   // fill count and response contents
   always_comb begin
      count_in  = count_ff;
      status_in = STATUS_NO_MATCH;
      found_in  = 32'd0;
      case (mode_ff)
         MODE_ADD: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               status_in = STATUS_DONE;
               count_in  = count_ff + CW'(1);
            end
         end
         MODE_FIND: begin
            if (hit) begin
               status_in = STATUS_DONE;
               found_in  = hit_time;
            end
         end
         MODE_DELETE: begin
            if (hit) begin
               status_in = STATUS_DONE;
               count_in  = count_ff - CW'(1);
            end
         end
         default: begin
            status_in = STATUS_NO_MATCH;
         end
      endcase
   end

   assign rsp_valid_in = go || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (go) begin
            count_ff <= count_in;
         end
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (go) begin
         status_ff <= status_in;
         found_ff  <= found_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_found_time = found_ff;

   // fill count never passes the depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("fill count beyond table depth");

   // live entries always form a prefix as long as the fill count
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      ch_valid[TABLE_DEPTH-1:0] == ~({TABLE_DEPTH{1'b1}} << count_ff))
      else $error("valid bits do not match fill count");

   // a completed add into a table with room grows it by one
   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      go && (mode_ff == MODE_ADD) && !full |=> count_ff == $past(count_ff) + CW'(1))
      else $error("add did not grow the table");

   // no new request while a transaction is in flight
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MATCH) || (state_ff == S_ACT) |-> req_stall)
      else $error("request taken while busy");

endmodule

// ===== rtl/ptpst_cell.sv =====
// one table entry: valid bit, key, time and a registered match flag
// depends on ptpst_pkg
module ptpst_cell
   import ptpst_pkg::*;
#(
   parameter int PORT_BITS = PORT_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctrl_type        ctrl,
   // request key and time
   input  logic [63:0]          key_clock_id,
   input  logic [15:0]          key_port_number,
   input  logic [15:0]          key_sequence_id,
   input  logic [PORT_BITS-1:0] key_in_port,
   input  logic [PORT_BITS-1:0] key_out_port,
   input  logic [31:0]          key_time,
   // contents of the next younger cell
   input  logic                 nbr_valid,
   input  logic [63:0]          nbr_clock_id,
   input  logic [15:0]          nbr_port_number,
   input  logic [15:0]          nbr_sequence_id,
   input  logic [PORT_BITS-1:0] nbr_in_port,
   input  logic [PORT_BITS-1:0] nbr_out_port,
   input  logic [31:0]          nbr_time,
   // own contents
   output logic                 valid,
   output logic [63:0]          clock_id,
   output logic [15:0]          port_number,
   output logic [15:0]          sequence_id,
   output logic [PORT_BITS-1:0] in_port,
   output logic [PORT_BITS-1:0] out_port,
   output logic [31:0]          time_val,
   output logic                 match
);

   logic                 valid_ff, valid_in;
   logic [63:0]          clock_id_ff;
   logic [15:0]          port_number_ff;
   logic [15:0]          sequence_id_ff;
   logic [PORT_BITS-1:0] in_port_ff;
   logic [PORT_BITS-1:0] out_port_ff;
   logic [31:0]          time_ff;
   logic                 match_ff, match_in;

   // key compare, only a live entry can match
   assign match_in = valid_ff && (clock_id_ff == key_clock_id) &&
                     (port_number_ff == key_port_number) &&
                     (sequence_id_ff == key_sequence_id) &&
                     (in_port_ff == key_in_port) && (out_port_ff == key_out_port);

   // valid bit follows the same source as the payload
   always_comb begin
      valid_in = valid_ff;
      if (ctrl.load) begin
         valid_in = 1'b1;
      end else if (ctrl.shift) begin
         valid_in = nbr_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctrl.compare) begin
            match_ff <= match_in;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         clock_id_ff    <= key_clock_id;
         port_number_ff <= key_port_number;
         sequence_id_ff <= key_sequence_id;
         in_port_ff     <= key_in_port;
         out_port_ff    <= key_out_port;
         time_ff        <= key_time;
      end else if (ctrl.shift) begin
         clock_id_ff    <= nbr_clock_id;
         port_number_ff <= nbr_port_number;
         sequence_id_ff <= nbr_sequence_id;
         in_port_ff     <= nbr_in_port;
         out_port_ff    <= nbr_out_port;
         time_ff        <= nbr_time;
      end
   end

   assign valid       = valid_ff;
   assign clock_id    = clock_id_ff;
   assign port_number = port_number_ff;
   assign sequence_id = sequence_id_ff;
   assign in_port     = in_port_ff;
   assign out_port    = out_port_ff;
   assign time_val    = time_ff;
   assign match       = match_ff;

endmodule

// ===== rtl/ptpst_select.sv =====
// picks the oldest matching cell: hit flag, shift mask and its time
// depends on ptpst_pkg
module ptpst_select
   import ptpst_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic [TABLE_DEPTH-1:0] match,
   input  logic [31:0]            cell_time [TABLE_DEPTH],
   output logic                   hit,
   output logic [TABLE_DEPTH-1:0] shift_mask,
   output logic [31:0]            hit_time
);

   logic [TABLE_DEPTH-1:0] first;

   // lowest set bit, then every cell at or above it
   assign first      = match & (~match + TABLE_DEPTH'(1));
   assign shift_mask = ~(first - TABLE_DEPTH'(1));
   assign hit        = |match;

   // one-hot mux of the stored times
   always_comb begin
      hit_time = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit_time = hit_time | (first[i] ? cell_time[i] : 32'd0);
      end
   end

endmodule

// ===== tb/sv/sync_table_checker.sv =====
// checker for the ptp sync timestamp table: keeps a shadow table, predicts each response
// and compares it with what the block returns
// depends on ptpst_pkg for the mode and status codes
`timescale 1ns / 100ps

module sync_table_checker
   import ptpst_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int PORT_BITS   = PORT_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [1:0]           req_mode,
   input  logic [63:0]          req_clock_identity,
   input  logic [15:0]          req_port_number,
   input  logic [15:0]          req_sequence_id,
   input  logic [PORT_BITS-1:0] req_in_port,
   input  logic [PORT_BITS-1:0] req_out_port,
   input  logic signed [31:0]   req_nanoseconds,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [1:0]           rsp_status,
   input  logic signed [31:0]   rsp_found_time,
   output int                   error_count,
   output int                   outstanding,
   output int                   full_hits,
   output int                   match_hits
);

   typedef struct packed {
      logic [63:0]          clock_id;
      logic [15:0]          port_number;
      logic [15:0]          sequence_id;
      logic [PORT_BITS-1:0] in_port;
      logic [PORT_BITS-1:0] out_port;
   } stamp_key_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] found_time;
   } stamp_response_type;

   // shadow of the table, oldest entry at index 0
   stamp_key_type      shadow_key [TABLE_DEPTH];
   logic signed [31:0] shadow_time [TABLE_DEPTH];
   int                 shadow_fill;

   stamp_response_type pending_responses [$];
   int                 mismatches;
   int                 full_total;
   int                 match_total;

   initial begin
      shadow_fill = 0;
      mismatches  = 0;
      full_total  = 0;
      match_total = 0;
      error_count = 0;
      outstanding = 0;
      full_hits   = 0;
      match_hits  = 0;
   end

   // apply one request to the shadow table and work out its response
   function automatic stamp_response_type predict_table_response(input logic [1:0] mode,
                                                                  input stamp_key_type key,
                                                                  input logic signed [31:0] ns);
      stamp_response_type res;
      int                 hit;
      res.status     = STATUS_NO_MATCH;
      res.found_time = '0;
      hit            = -1;
      // oldest matching entry wins
      for (int i = 0; i < shadow_fill; i++)
         if (hit < 0 && shadow_key[i] == key)
            hit = i;
      case (mode)
         MODE_ADD: begin
            if (shadow_fill >= TABLE_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               shadow_key[shadow_fill]  = key;
               shadow_time[shadow_fill] = ns;
               shadow_fill++;
               res.status = STATUS_DONE;
            end
         end
         MODE_FIND: begin
            if (hit >= 0) begin
               res.found_time = shadow_time[hit];
               res.status     = STATUS_DONE;
            end
         end
         MODE_DELETE: begin
            // close the gap left by the removed entry
            if (hit >= 0) begin
               for (int i = hit; i < shadow_fill - 1; i++) begin
                  shadow_key[i]  = shadow_key[i+1];
                  shadow_time[i] = shadow_time[i+1];
               end
               shadow_fill--;
               res.status = STATUS_DONE;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // response side first: a response never belongs to a request taken at the same edge
   always @(posedge clock) begin : watch_channels
      stamp_response_type expected;
      stamp_key_type      key;
      if (reset) begin
         shadow_fill = 0;
         pending_responses.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_responses.size() == 0) begin
               $error("response transaction with nothing outstanding: status %0d time %0d",
                      rsp_status, rsp_found_time);
               mismatches++;
            end else begin
               expected = pending_responses.pop_front();
               if (rsp_status !== expected.status) begin
                  $error("rsp_status: expected %0d, actual %0d", expected.status, rsp_status);
                  mismatches++;
               end
               if (rsp_found_time !== expected.found_time) begin
                  $error("rsp_found_time: expected %0d, actual %0d",
                         expected.found_time, rsp_found_time);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            key.clock_id    = req_clock_identity;
            key.port_number = req_port_number;
            key.sequence_id = req_sequence_id;
            key.in_port     = req_in_port;
            key.out_port    = req_out_port;
            expected = predict_table_response(req_mode, key, req_nanoseconds);
            if (expected.status == STATUS_FULL)
               full_total++;
            if (expected.status == STATUS_DONE && req_mode != MODE_ADD)
               match_total++;
            pending_responses.push_back(expected);
         end
      end
      error_count <= mismatches;
      outstanding <= pending_responses.size();
      full_hits   <= full_total;
      match_hits  <= match_total;
   end

endmodule

// ===== tb/sv/tb_ptp_sync_timestamp_table.sv =====
// top of the ptp sync timestamp table testbench: clock, reset, request and response traffic
// depends on ptpst_pkg, ptp_sync_timestamp_table and sync_table_checker
`timescale 1ns / 100ps

module tb_ptp_sync_timestamp_table;
   import ptpst_pkg::*;

   localparam int DEPTH        = TABLE_DEPTH_DEF;
   localparam int PW           = PORT_BITS_DEF;
   localparam int ITEM_TARGET  = 1200;
   localparam int PHASE_ITEMS  = 80;
   localparam int POOL_SIZE    = 8;
   localparam int HOLD_CYCLES  = 200;
   localparam int SETTLE       = 10;
   localparam int CYCLE_LIMIT  = 100000;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [63:0]   clock_id;
      logic [15:0]   port_number;
      logic [15:0]   sequence_id;
      logic [PW-1:0] in_port;
      logic [PW-1:0] out_port;
   } sync_key_type;

   localparam int KEY_BITS = $bits(sync_key_type);

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [1:0]          req_mode;
   logic [63:0]         req_clock_identity;
   logic [15:0]         req_port_number;
   logic [15:0]         req_sequence_id;
   logic [PW-1:0]       req_in_port;
   logic [PW-1:0]       req_out_port;
   logic signed [31:0]  req_nanoseconds;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [1:0]          rsp_status;
   logic signed [31:0]  rsp_found_time;

   int error_count;
   int outstanding;
   int full_hits;
   int match_hits;

   int           cycle_count;
   int           items_sent;
   int           mode_count [4];
   logic         quiet;
   logic         no_gaps;
   int           hold_asks;
   int           holds_served;
   int           hold_left;
   sync_key_type key_pool [POOL_SIZE];
   sync_key_type recent_keys [$];

   ptp_sync_timestamp_table #(
      .TABLE_DEPTH (DEPTH),
      .PORT_BITS   (PW)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_clock_identity (req_clock_identity),
      .req_port_number    (req_port_number),
      .req_sequence_id    (req_sequence_id),
      .req_in_port        (req_in_port),
      .req_out_port       (req_out_port),
      .req_nanoseconds    (req_nanoseconds),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found_time     (rsp_found_time)
   );

   sync_table_checker #(
      .TABLE_DEPTH (DEPTH),
      .PORT_BITS   (PW)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_clock_identity (req_clock_identity),
      .req_port_number    (req_port_number),
      .req_sequence_id    (req_sequence_id),
      .req_in_port        (req_in_port),
      .req_out_port       (req_out_port),
      .req_nanoseconds    (req_nanoseconds),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found_time     (rsp_found_time),
      .error_count        (error_count),
      .outstanding        (outstanding),
      .full_hits          (full_hits),
      .match_hits         (match_hits)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, outstanding);
         $display("FAIL");
         $finish;
      end
   end

   // response side: random stalls, a long hold-off on request, none while quiet
   initial begin
      holds_served = 0;
      hold_left    = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != holds_served) begin
            holds_served = hold_asks;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 12);
         end
      end
   end

   function automatic sync_key_type random_key();
      sync_key_type k;
      k.clock_id    = {$urandom, $urandom};
      k.port_number = 16'($urandom);
      k.sequence_id = 16'($urandom);
      k.in_port     = PW'($urandom);
      k.out_port    = PW'($urandom);
      return k;
   endfunction

   // one request transaction, held until taken, then maybe a random gap
   task automatic offer_transaction(input logic [1:0] mode, input sync_key_type key,
                                    input logic signed [31:0] ns);
      sync_key_type junk;
      req_valid          <= 1'b1;
      req_mode           <= mode;
      req_clock_identity <= key.clock_id;
      req_port_number    <= key.port_number;
      req_sequence_id    <= key.sequence_id;
      req_in_port        <= key.in_port;
      req_out_port       <= key.out_port;
      req_nanoseconds    <= ns;
      do @(posedge clock); while (req_stall);
      items_sent++;
      mode_count[mode]++;
      // idle with scrambled payload, which the block must ignore
      if (!quiet && !no_gaps && $urandom_range(99) < 12) begin
         junk = random_key();
         req_valid          <= 1'b0;
         req_mode           <= 2'($urandom);
         req_clock_identity <= junk.clock_id;
         req_sequence_id    <= junk.sequence_id;
         req_nanoseconds    <= $urandom;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // sender pause: let every response come back
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // random transaction with the given mode mix in percent, the rest unused mode
   task automatic random_transaction(input int add_pct, input int find_pct, input int del_pct);
      logic [1:0]   mode;
      sync_key_type key;
      int           roll;
      roll = $urandom_range(99);
      if (roll < add_pct)
         mode = MODE_ADD;
      else if (roll < add_pct + find_pct)
         mode = MODE_FIND;
      else if (roll < add_pct + find_pct + del_pct)
         mode = MODE_DELETE;
      else
         mode = MODE_UNUSED;
      // mostly keys from the pool so lookups hit; fresh keys now and then
      roll = $urandom_range(99);
      if (mode == MODE_ADD) begin
         if (roll < 85) begin
            key = key_pool[$urandom_range(POOL_SIZE-1)];
         end else begin
            key = random_key();
            recent_keys.push_back(key);
            if (recent_keys.size() > 16)
               recent_keys.delete(0);
         end
      end else if (roll < 70) begin
         key = key_pool[$urandom_range(POOL_SIZE-1)];
      end else if (roll < 88 && recent_keys.size() > 0) begin
         key = recent_keys[$urandom_range(recent_keys.size()-1)];
      end else begin
         key = random_key();
      end
      offer_transaction(mode, key, $urandom);
   endtask

   initial begin : stimulus
      sync_key_type key_a;
      sync_key_type key_a_near;
      sync_key_type key_b;
      sync_key_type key_b_near;
      int           phase;
      int           kind;

      items_sent = 0;
      for (int m = 0; m < 4; m++)
         mode_count[m] = 0;
      recent_keys.delete();
      hold_asks <= 0;
      quiet     <= 1'b0;
      no_gaps   <= 1'b0;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_mode           <= MODE_ADD;
      req_clock_identity <= '0;
      req_port_number    <= '0;
      req_sequence_id    <= '0;
      req_in_port        <= '0;
      req_out_port       <= '0;
      req_nanoseconds    <= '0;

      // keys: odd entries differ from an earlier one in a single bit
      for (int i = 0; i < POOL_SIZE; i++) begin
         if (i % 2 == 0)
            key_pool[i] = random_key();
         else
            key_pool[i] = key_pool[$urandom_range(i-1)]
                          ^ (sync_key_type'(1) << $urandom_range(KEY_BITS-1));
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extremes, duplicates, near misses, unused mode
      key_a      = '1;
      key_b      = '0;
      key_a_near = key_a;
      key_a_near.sequence_id[0] = 1'b0;
      key_b_near = key_b;
      key_b_near.in_port[PW-1] = 1'b1;
      offer_transaction(MODE_DELETE, key_a, 32'sd0);
      offer_transaction(MODE_FIND, key_b, 32'sd0);
      offer_transaction(MODE_UNUSED, key_a, 32'sd0);
      offer_transaction(MODE_ADD, key_a, 32'sh8000_0000);
      offer_transaction(MODE_ADD, key_b, 32'sh7fff_ffff);
      offer_transaction(MODE_ADD, key_a, -32'sd1);
      offer_transaction(MODE_ADD, key_a_near, 32'sd12345);
      offer_transaction(MODE_FIND, key_a, 32'sd0);
      offer_transaction(MODE_FIND, key_a_near, 32'sd0);
      offer_transaction(MODE_FIND, key_b_near, 32'sd0);
      offer_transaction(MODE_DELETE, key_a, 32'sd0);
      offer_transaction(MODE_FIND, key_a, 32'sd0);
      offer_transaction(MODE_UNUSED, key_b, 32'sd0);
      offer_transaction(MODE_FIND, key_b, 32'sd0);
      offer_transaction(MODE_DELETE, key_b, 32'sd0);
      offer_transaction(MODE_DELETE, key_b, 32'sd0);
      offer_transaction(MODE_DELETE, key_a, 32'sd0);
      offer_transaction(MODE_DELETE, key_a, 32'sd0);
      offer_transaction(MODE_DELETE, key_a_near, 32'sd0);
      offer_transaction(MODE_FIND, key_a_near, 32'sd0);
      wait_for_responses();

      // random phases: fill past full, mixed traffic, drain towards empty
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         kind = phase % 4;
         if (phase == 1) begin
            // long response hold-off while requests keep coming back to back
            hold_asks <= hold_asks + 1;
            no_gaps   <= 1'b1;
         end else if (phase == 5) begin
            quiet <= 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            case (kind)
               0:       random_transaction(75, 15, 8);
               2:       random_transaction(10, 30, 57);
               default: random_transaction(35, 35, 25);
            endcase
         end
         no_gaps <= 1'b0;
         quiet   <= 1'b0;
         if (phase % 3 == 2)
            wait_for_responses();
         phase++;
      end

      // closing: everything back, then a quiet settling wait for stray responses
      wait_for_responses();
      repeat (SETTLE) @(posedge clock);

      $display("run covered %0d requests: %0d add, %0d find, %0d delete, %0d unused mode",
               items_sent, mode_count[MODE_ADD], mode_count[MODE_FIND],
               mode_count[MODE_DELETE], mode_count[MODE_UNUSED]);
      $display("%0d lookups matched, %0d adds hit a full table, %0d mismatches",
               match_hits, full_hits, error_count);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
